// File: hdl/bmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_pkg
// Types and constants shared by the boot memory map usable-sum blocks.
// ----------------------------------------------------------------------------
package bmm_pkg;

  typedef struct packed {
    logic [7:0] info_byte;
    logic       first_byte;
  } bmm_item_t;

  typedef struct packed {
    logic [31:0] total_kb;
    logic [1:0]  status;
  } bmm_result_t;

  localparam logic [1:0] ST_END_TAG   = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_BAD_MAGIC = 2'd2;
  localparam logic [1:0] ST_MALFORMED = 2'd3;

  localparam logic [31:0] MB2_MAGIC      = 32'h36D7_6289;
  localparam logic [31:0] FALLBACK_KB    = 32'd131072;
  localparam logic [31:0] DEFAULT_STRIDE = 32'd24;
  localparam logic [31:0] MMAP_HEADER    = 32'd16;
  localparam logic [31:0] ALIGN_MASK     = 32'd7;
  localparam logic [31:0] TAG_HEADER     = 32'd8;
  localparam logic [31:0] MMAP_KIND      = 32'd6;
  localparam logic [31:0] USABLE_KIND    = 32'd1;
  localparam logic [31:0] MIN_ENTRY      = 32'd20;
  localparam logic [31:0] MAX_TAG_LENGTH = 32'hFFFF_FFF8;
  localparam int          KB_SHIFT       = 10;

endpackage

// File: hdl/bmm_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_in_stage
// Input register: captures one request and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module bmm_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  bmm_pkg::bmm_item_t item,
  input  logic               advance,
  output logic               held_valid,
  output bmm_pkg::bmm_item_t held
);
  import bmm_pkg::*;

  logic accept;

  // hold the request while the parser cannot advance
  assign item_stall = held_valid & ~advance;
  assign accept     = item_valid & ~item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= item;
    end
  end

endmodule

// File: hdl/bmm_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_parse
// Byte-wise multiboot2 tag walker; sums usable memory map entry lengths.
// ----------------------------------------------------------------------------
module bmm_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  bmm_pkg::bmm_item_t   item,
  input  logic [31:0]          boot_magic,
  output logic                 res_valid,
  output bmm_pkg::bmm_result_t res
);
  import bmm_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'b01,
    PH_PARSE = 2'b10
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] block_size, block_size_next;
  logic [31:0] block_offset, block_offset_next;
  logic [31:0] tag_offset, tag_offset_next;
  logic [31:0] tag_kind, tag_kind_next;
  logic [31:0] tag_length, tag_length_next;
  logic [31:0] entry_stride, entry_stride_next;
  logic [31:0] entry_offset, entry_offset_next;
  logic        entry_live, entry_live_next;
  logic [63:0] entry_length, entry_length_next;
  logic [23:0] entry_kind, entry_kind_next;
  logic [63:0] usable_bytes, usable_bytes_next;

  logic [7:0]  b;
  logic        go;
  logic [31:0] o;
  logic [31:0] r;
  logic [31:0] len_full;
  logic [31:0] len_now;
  logic [31:0] len_align;
  logic [32:0] next_tag;
  logic [32:0] o_inc;
  logic        at_next;
  logic        next_exhausted;
  logic [31:0] stride_full;
  logic [31:0] stride_eff;
  logic        is_mmap;
  logic        live_now;
  logic [32:0] e_inc;
  logic        add_now;
  logic [63:0] usable_sum;
  logic        emit;
  logic [1:0]  emit_status;

  always_comb begin
    b          = item.info_byte;
    o          = item.first_byte ? 32'd0 : block_offset;
    r          = o - tag_offset;
    len_full   = {b, tag_length[23:0]};
    len_now    = (r == TAG_HEADER - 32'd1) ? len_full : tag_length;
    len_align  = (len_now + ALIGN_MASK) & ~ALIGN_MASK;
    next_tag   = {1'b0, tag_offset} + {1'b0, len_align};
    o_inc      = {1'b0, o} + 33'd1;
    at_next    = (r >= TAG_HEADER - 32'd1) && (o_inc >= next_tag);
    next_exhausted = ({1'b0, next_tag} + {2'b00, TAG_HEADER}) > {2'b00, block_size};
    stride_full = {b, entry_stride[23:0]};
    stride_eff  = (stride_full == 32'd0) ? DEFAULT_STRIDE : stride_full;
    is_mmap     = (tag_kind == MMAP_KIND) && (tag_length >= MMAP_HEADER);
    // an entry counts only if it ends inside the tag
    live_now    = (entry_offset == 32'd0)
                ? (({1'b0, r} + {1'b0, entry_stride}) <= {1'b0, tag_length})
                : entry_live;
    e_inc       = {1'b0, entry_offset} + 33'd1;
    add_now     = is_mmap && (o >= TAG_HEADER) && (r >= MMAP_HEADER) && live_now
                  && (entry_offset == MIN_ENTRY - 32'd1)
                  && ({b, entry_kind} == USABLE_KIND);
    usable_sum  = add_now ? usable_bytes + entry_length : usable_bytes;
  end

  always_comb begin
    phase_next        = phase;
    block_size_next   = block_size;
    block_offset_next = block_offset;
    tag_offset_next   = tag_offset;
    tag_kind_next     = tag_kind;
    tag_length_next   = tag_length;
    entry_stride_next = entry_stride;
    entry_offset_next = entry_offset;
    entry_live_next   = entry_live;
    entry_length_next = entry_length;
    entry_kind_next   = entry_kind;
    usable_bytes_next = usable_bytes;
    emit              = 1'b0;
    emit_status       = ST_END_TAG;
    go                = 1'b0;
    res_valid         = 1'b0;
    res.total_kb      = usable_sum[KB_SHIFT +: 32];
    res.status        = ST_END_TAG;

    if (fire) begin
      if (item.first_byte) begin
        usable_bytes_next = 64'd0;
        if (boot_magic != MB2_MAGIC) begin
          res_valid    = 1'b1;
          res.total_kb = FALLBACK_KB;
          res.status   = ST_BAD_MAGIC;
          phase_next   = PH_IDLE;
        end else begin
          go = 1'b1;
        end
      end else begin
        go = (phase == PH_PARSE);
      end
    end

    if (go) begin
      phase_next        = PH_PARSE;
      block_offset_next = o + 32'd1;
      if (o < TAG_HEADER) begin
        // block header: size, then reserved word
        if (o < 32'd4) begin
          block_size_next[8*o[1:0] +: 8] = b;
        end
        if (o == TAG_HEADER - 32'd1) begin
          if (block_size < TAG_HEADER + TAG_HEADER) begin
            emit        = 1'b1;
            emit_status = ST_EXHAUSTED;
          end else begin
            tag_offset_next   = TAG_HEADER;
            entry_offset_next = 32'd0;
          end
        end
      end else begin
        if (r < 32'd4) begin
          tag_kind_next[8*r[1:0] +: 8] = b;
        end else if (r < TAG_HEADER) begin
          tag_length_next[8*r[1:0] +: 8] = b;
          if (r == TAG_HEADER - 32'd1) begin
            if (tag_kind == 32'd0) begin
              emit        = 1'b1;
              emit_status = ST_END_TAG;
            end else if (len_full < TAG_HEADER || len_full > MAX_TAG_LENGTH) begin
              emit        = 1'b1;
              emit_status = ST_MALFORMED;
            end
          end
        end else if (is_mmap) begin
          if (r < 32'd12) begin
            entry_stride_next[8*r[1:0] +: 8] = b;
            if (r == 32'd11) begin
              entry_stride_next = stride_eff;
              entry_offset_next = 32'd0;
              if (stride_eff < MIN_ENTRY && (tag_length - MMAP_HEADER) >= stride_eff) begin
                emit        = 1'b1;
                emit_status = ST_MALFORMED;
              end
            end
          end else if (r >= MMAP_HEADER) begin
            entry_live_next = live_now;
            if (live_now) begin
              if (entry_offset >= 32'd8 && entry_offset < 32'd16) begin
                entry_length_next[8*entry_offset[2:0] +: 8] = b;
              end else if (entry_offset >= 32'd16 && entry_offset < MIN_ENTRY - 32'd1) begin
                entry_kind_next[8*entry_offset[1:0] +: 8] = b;
              end
              if (add_now) begin
                usable_bytes_next = usable_sum;
              end
              entry_offset_next = (e_inc >= {1'b0, entry_stride}) ? 32'd0 : e_inc[31:0];
            end
          end
        end

        if (!emit) begin
          if (at_next) begin
            if (next_exhausted) begin
              emit        = 1'b1;
              emit_status = ST_EXHAUSTED;
            end else begin
              tag_offset_next   = next_tag[31:0];
              entry_offset_next = 32'd0;
            end
          end else if (o == 32'hFFFF_FFFF) begin
            emit        = 1'b1;
            emit_status = ST_EXHAUSTED;
          end
        end
      end

      if (emit) begin
        res_valid  = 1'b1;
        res.status = emit_status;
        phase_next = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    block_size   <= block_size_next;
    block_offset <= block_offset_next;
    tag_offset   <= tag_offset_next;
    tag_kind     <= tag_kind_next;
    tag_length   <= tag_length_next;
    entry_stride <= entry_stride_next;
    entry_offset <= entry_offset_next;
    entry_live   <= entry_live_next;
    entry_length <= entry_length_next;
    entry_kind   <= entry_kind_next;
    usable_bytes <= usable_bytes_next;
  end

endmodule

// File: hdl/bmm_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_out_stage
// Result register: holds a finished result until the receiver takes it.
// ----------------------------------------------------------------------------
module bmm_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  bmm_pkg::bmm_result_t load_data,
  output logic                 advance,
  output logic                 result_valid,
  input  logic                 result_stall,
  output bmm_pkg::bmm_result_t result
);
  import bmm_pkg::*;

  // free when empty or being drained this cycle
  assign advance = ~result_valid | ~result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= load_data;
    end
  end

endmodule

// File: hdl/boot_memory_map_usable_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boot_memory_map_usable_sum
// Parses a multiboot2 boot information block one byte per request and
// reports usable memory in KiB.
//
//   channel   direction  handshake                 payload
//   item      in         item_valid / item_stall   info_byte, first_byte
//   result    out        result_valid / result_stall  total_kb, status
//   magic     in         magic_we                  magic_wdata (boot magic)
//
// One byte per cycle sustained while result_stall is low; each byte is held in
// the input register while the parser step updates its state and loads the result register.
// A result passes through the input register and then the result register, at most one per byte.
// rst is synchronous and clears the valids, the parser phase and boot magic.
// A stalled result blocks the parser, which in turn stalls the item channel.
// ----------------------------------------------------------------------------
module boot_memory_map_usable_sum (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  bmm_pkg::bmm_item_t   item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output bmm_pkg::bmm_result_t result,
  input  logic                 magic_we,
  input  logic [31:0]          magic_wdata
);
  import bmm_pkg::*;

  logic        boot_magic;
  logic [31:0] magic;
  logic        advance;
  logic        held_valid;
  bmm_item_t   held;
  logic        fire;
  logic        res_valid;
  bmm_result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic <= 32'd0;
    end else if (magic_we) begin
      magic <= magic_wdata;
    end
  end

  assign boot_magic = (magic == MB2_MAGIC);
  assign fire       = held_valid & advance;

  bmm_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .advance    (advance),
    .held_valid (held_valid),
    .held       (held)
  );

  bmm_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .item       (held),
    .boot_magic (boot_magic ? MB2_MAGIC : magic),
    .res_valid  (res_valid),
    .res        (res)
  );

  bmm_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (fire & res_valid),
    .load_data    (res),
    .advance      (advance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
